### sv/hda_pkg.sv
// Shared types and constants for the Hankel anti-diagonal averaging block.
// No dependencies; every other file imports this package.
`default_nettype none

package hda_pkg;

   // Default size of the largest matrix dimension
   localparam int HDA_MAX_DIM = 1024;

   // Fixed field widths
   localparam int SAMPLE_W   = 32;
   localparam int CFG_W      = 11;
   localparam int DIAG_W     = 11;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   // Register index, taken from paddr[2]
   localparam logic REG_ROWS = 1'b0;
   localparam logic REG_COLS = 1'b1;

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_UPDATE,
      ST_DIVIDE,
      ST_OUTPUT
   } ctrl_state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic accept;
      logic mem_write;
      logic div_start;
      logic load_out;
   } ctrl_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic emit;
      logic div_busy;
      logic out_free;
   } ctrl_stat_type;

endpackage

`default_nettype wire

### sv/hda_req_if.sv
// Input channel: one matrix sample per beat.
// Depends on hda_pkg for the sample width.
`default_nettype none

interface hda_req_if import hda_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample_value;

   modport source (output valid, output sample_value, input ready);
   modport sink   (input valid, input sample_value, output ready);
endinterface

`default_nettype wire

### sv/hda_rsp_if.sv
// Result channel: one diagonal average per beat.
// Depends on hda_pkg for the field widths.
`default_nettype none

interface hda_rsp_if import hda_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] average_value;
   logic        [DIAG_W-1:0]   diagonal_index;
   logic                       last_result;

   modport source (output valid, output average_value, output diagonal_index,
                   output last_result, input ready);
   modport sink   (input valid, input average_value, input diagonal_index,
                   input last_result, output ready);
endinterface

`default_nettype wire

### sv/hda_csr.sv
// APB register file: matrix_rows and matrix_cols, clamped to 1..MAX_DIM.
// Depends on hda_pkg; a write pulses restart to rewind the matrix position.
`default_nettype none

module hda_csr import hda_pkg::*; #(
   parameter  int MAX_DIM = HDA_MAX_DIM,
   localparam int DIM_W   = $clog2(MAX_DIM + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output logic [DIM_W-1:0]      eff_rows,
   output logic [DIM_W-1:0]      eff_cols,
   output logic                  restart
);

   logic [CFG_W-1:0] rows_ff, rows_in;
   logic [CFG_W-1:0] cols_ff, cols_in;
   logic             wr_en;

   // Map zero to one and cap at the largest dimension
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] raw);
      logic [31:0] wide;
      wide = 32'(raw);
      if (wide == 32'd0) begin
         clamp_dim = DIM_W'(1);
      end else if (wide > 32'(MAX_DIM)) begin
         clamp_dim = DIM_W'(MAX_DIM);
      end else begin
         clamp_dim = DIM_W'(raw);
      end
   endfunction

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign restart    = wr_en;

   // Decode the write
   always_comb begin
      rows_in = rows_ff;
      cols_in = cols_ff;
      if (wr_en) begin
         case (csr_paddr[2])
            REG_ROWS: rows_in = csr_pwdata[CFG_W-1:0];
            REG_COLS: cols_in = csr_pwdata[CFG_W-1:0];
            default:  rows_in = rows_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= CFG_W'(1);
         cols_ff <= CFG_W'(1);
      end else begin
         rows_ff <= rows_in;
         cols_ff <= cols_in;
      end
   end

   // Read back the raw register values
   assign csr_prdata = (csr_paddr[2] == REG_COLS) ? CSR_DATA_W'(cols_ff)
                                                  : CSR_DATA_W'(rows_ff);

   assign eff_rows = clamp_dim(rows_ff);
   assign eff_cols = clamp_dim(cols_ff);

endmodule

`default_nettype wire

### sv/hda_divider.sv
// Radix-2 restoring divider: signed sum over a small unsigned count,
// quotient truncated toward zero. A setup step takes the magnitude, then one bit per cycle.
`default_nettype none

module hda_divider import hda_pkg::*; #(
   parameter int SUM_W = 42,
   parameter int DIV_W = 11
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic signed [SUM_W-1:0]    dividend,
   input  logic        [DIV_W-1:0]    divisor,
   output logic                       busy,
   output logic signed [SAMPLE_W-1:0] quotient
);

   localparam int STEP_W = $clog2(SUM_W + 2);

   logic              busy_ff;
   logic [STEP_W-1:0] step_ff;
   logic [SUM_W-1:0]  quo_ff;
   logic [DIV_W-1:0]  rem_ff;
   logic [DIV_W-1:0]  den_ff;
   logic              neg_ff;

   logic [DIV_W:0]    shifted;
   logic [DIV_W+1:0]  trial;
   logic              fits;

   // One trial subtraction per step
   assign shifted = {rem_ff, quo_ff[SUM_W-1]};
   assign trial   = {1'b0, shifted} - {2'b00, den_ff};
   assign fits    = ~trial[DIV_W+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (start) begin
         busy_ff <= 1'b1;
      end else if (busy_ff && step_ff == STEP_W'(1)) begin
         busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff  <= dividend;
         neg_ff  <= dividend[SUM_W-1];
         den_ff  <= divisor;
         rem_ff  <= '0;
         step_ff <= STEP_W'(SUM_W + 1);
      end else if (busy_ff) begin
         step_ff <= step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(SUM_W + 1)) begin
            // Setup step: take the magnitude
            if (neg_ff) begin
               quo_ff <= -quo_ff;
            end
         end else begin
            rem_ff <= fits ? trial[DIV_W-1:0] : shifted[DIV_W-1:0];
            quo_ff <= {quo_ff[SUM_W-2:0], fits};
         end
      end
   end

   assign busy     = busy_ff;
   assign quotient = neg_ff ? -quo_ff[SAMPLE_W-1:0] : quo_ff[SAMPLE_W-1:0];

endmodule

`default_nettype wire

### sv/hda_datapath.sv
// Datapath: matrix position counters, diagonal sum memory with
// read-modify-write, element count, divider and result register.
// Depends on hda_pkg and hda_divider.
`default_nettype none

module hda_datapath import hda_pkg::*; #(
   parameter  int MAX_DIM = HDA_MAX_DIM,
   localparam int DIM_W   = $clog2(MAX_DIM + 1)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       restart,
   input  logic [DIM_W-1:0]           eff_rows,
   input  logic [DIM_W-1:0]           eff_cols,
   input  ctrl_cmd_type               cmd,
   output ctrl_stat_type              stat,
   input  logic signed [SAMPLE_W-1:0] sample_value,
   input  logic                       rsp_ready,
   output logic                       rsp_valid,
   output logic signed [SAMPLE_W-1:0] average_value,
   output logic [DIAG_W-1:0]          diagonal_index,
   output logic                       last_result
);

   localparam int POS_W = $clog2(MAX_DIM);
   localparam int K_W   = $clog2(2 * MAX_DIM);
   localparam int EXT_W = K_W + 1;
   localparam int SUM_W = SAMPLE_W + $clog2(MAX_DIM);
   localparam int DEPTH = 2 * MAX_DIM;

   // Position of the next element
   logic [POS_W-1:0] row_ff, row_in;
   logic [POS_W-1:0] col_ff, col_in;

   // Item captured at accept
   logic signed [SAMPLE_W-1:0] sample_ff;
   logic [K_W-1:0]             k_ff;
   logic                       first_ff;
   logic                       emit_ff;
   logic                       last_ff;

   logic [K_W-1:0]   k_now;
   logic             row_end;
   logic             col_end;
   logic             first_now;
   logic             emit_now;
   logic             last_now;

   // Diagonal sum memory
   logic [SUM_W-1:0] sums_mem [DEPTH];
   logic [SUM_W-1:0] rd_ff;
   logic [SUM_W-1:0] sample_ext;
   logic [SUM_W-1:0] sum_new;

   // Element count of the current diagonal
   logic [EXT_W-1:0] cnt_a, cnt_b, cnt_c, cnt_d, cnt_ab, cnt_cd, cnt_min;
   logic [DIM_W-1:0] cnt;

   logic                       div_busy;
   logic signed [SAMPLE_W-1:0] quotient;

   // Result register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] avg_ff;
   logic [DIAG_W-1:0]          diag_ff;
   logic                       last_out_ff;

   // Classify the element at the current position
   assign k_now     = K_W'(row_ff) + K_W'(col_ff);
   assign row_end   = (DIM_W'(row_ff) == eff_rows - DIM_W'(1));
   assign col_end   = (DIM_W'(col_ff) == eff_cols - DIM_W'(1));
   assign first_now = (row_ff == '0) || col_end;
   assign emit_now  = (col_ff == '0) || row_end;
   assign last_now  = (EXT_W'(k_now) ==
                       EXT_W'(eff_rows) + EXT_W'(eff_cols) - EXT_W'(2));

   // Advance in row-major order, wrap at the end of the matrix
   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      if (restart) begin
         row_in = '0;
         col_in = '0;
      end else if (cmd.accept) begin
         if (col_end) begin
            col_in = '0;
            row_in = row_end ? '0 : row_ff + POS_W'(1);
         end else begin
            col_in = col_ff + POS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

   // Capture the item
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         sample_ff <= sample_value;
         k_ff      <= k_now;
         first_ff  <= first_now;
         emit_ff   <= emit_now;
         last_ff   <= last_now;
      end
   end

   // Start a diagonal or add into it
   assign sample_ext = {{(SUM_W-SAMPLE_W){sample_ff[SAMPLE_W-1]}}, sample_ff};
   assign sum_new    = first_ff ? sample_ext : rd_ff + sample_ext;

   always_ff @(posedge clock) begin
      if (cmd.mem_write) begin
         sums_mem[k_ff] <= sum_new;
      end
      rd_ff <= sums_mem[k_ff];
   end

   // Count = min(k+1, rows, cols, rows+cols-1-k)
   assign cnt_a   = EXT_W'(k_ff) + EXT_W'(1);
   assign cnt_b   = EXT_W'(eff_rows);
   assign cnt_c   = EXT_W'(eff_cols);
   assign cnt_d   = EXT_W'(eff_rows) + EXT_W'(eff_cols) - EXT_W'(1) - EXT_W'(k_ff);
   assign cnt_ab  = (cnt_a < cnt_b) ? cnt_a : cnt_b;
   assign cnt_cd  = (cnt_c < cnt_d) ? cnt_c : cnt_d;
   assign cnt_min = (cnt_ab < cnt_cd) ? cnt_ab : cnt_cd;
   assign cnt     = cnt_min[DIM_W-1:0];

   hda_divider #(
      .SUM_W (SUM_W),
      .DIV_W (DIM_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (sum_new),
      .divisor  (cnt),
      .busy     (div_busy),
      .quotient (quotient)
   );

   // Hold the result until the beat is taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         avg_ff      <= quotient;
         diag_ff     <= DIAG_W'(k_ff);
         last_out_ff <= last_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign average_value  = avg_ff;
   assign diagonal_index = diag_ff;
   assign last_result    = last_out_ff;

   assign stat.emit     = emit_ff;
   assign stat.div_busy = div_busy;
   assign stat.out_free = ~rsp_valid_ff | rsp_ready;

endmodule

`default_nettype wire

### sv/hda_ctrl.sv
// Controller: sequences accept, memory read, update, divide and output.
// Depends on hda_pkg for the state and command types.
`default_nettype none

module hda_ctrl import hda_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  ctrl_stat_type stat,
   output ctrl_cmd_type  cmd
);

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.mem_write = 1'b1;
            if (stat.emit) begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIVIDE;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_DIVIDE: begin
            if (!stat.div_busy) begin
               state_in = ST_OUTPUT;
            end
         end
         ST_OUTPUT: begin
            if (stat.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

### sv/hankel_diagonal_averaging.sv
// Top level of the Hankel anti-diagonal averaging block.
// Depends on hda_pkg, hda_req_if, hda_rsp_if, hda_csr, hda_ctrl, hda_datapath.
//
//   channel | direction | beat contents
//   --------+-----------+------------------------------------------------
//   req     | in        | sample_value (Q16.16), row-major matrix entry
//   rsp     | out       | average_value, diagonal_index, last_result
//   csr     | APB       | 0x0 matrix_rows, 0x4 matrix_cols
//
// One item at a time. An item that ends no diagonal passes through accept,
// memory read and write back. An item that ends a diagonal adds the divider,
// which yields one quotient bit per cycle, and then the output step, which
// waits while the result register is stalled.
// Reset is synchronous and needs no clearing pass; the sum memory's
// read value is never used before its diagonal's first element writes it.
`default_nettype none

module hankel_diagonal_averaging import hda_pkg::*; #(
   parameter int MAX_DIM = HDA_MAX_DIM
) (
   input  logic                  clock,
   input  logic                  reset,
   hda_req_if.sink               req,
   hda_rsp_if.source             rsp,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int DIM_W = $clog2(MAX_DIM + 1);

   logic [DIM_W-1:0] eff_rows;
   logic [DIM_W-1:0] eff_cols;
   logic             restart;
   ctrl_cmd_type     cmd;
   ctrl_stat_type    stat;

   hda_csr #(
      .MAX_DIM (MAX_DIM)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .eff_rows    (eff_rows),
      .eff_cols    (eff_cols),
      .restart     (restart)
   );

   hda_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   hda_datapath #(
      .MAX_DIM (MAX_DIM)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .restart        (restart),
      .eff_rows       (eff_rows),
      .eff_cols       (eff_cols),
      .cmd            (cmd),
      .stat           (stat),
      .sample_value   (req.sample_value),
      .rsp_ready      (rsp.ready),
      .rsp_valid      (rsp.valid),
      .average_value  (rsp.average_value),
      .diagonal_index (rsp.diagonal_index),
      .last_result    (rsp.last_result)
   );

endmodule

`default_nettype wire

### sv/hda_checker.sv
// Port-level checks for hankel_diagonal_averaging, attached by bind.
// Depends on hda_pkg for the field widths.
`default_nettype none

module hda_checker import hda_pkg::*; (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic signed [SAMPLE_W-1:0] average_value,
   input logic [DIAG_W-1:0]          diagonal_index,
   input logic                       last_result
);

   // One item in flight: an accepted beat drops ready on the next cycle
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("req accepted again while an item is in flight");

   // Reset empties the result register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

   // A stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("rsp beat dropped while stalled");

   // A stalled result keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         ($stable(average_value) && $stable(diagonal_index) && $stable(last_result)))
      else $error("rsp payload changed while stalled");

endmodule

bind hankel_diagonal_averaging hda_checker u_hda_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req.valid),
   .req_ready      (req.ready),
   .rsp_valid      (rsp.valid),
   .rsp_ready      (rsp.ready),
   .average_value  (rsp.average_value),
   .diagonal_index (rsp.diagonal_index),
   .last_result    (rsp.last_result)
);

`default_nettype wire
